/* src/i2ctw_pkg.sv */
// ----------------------------------------------------------------------------
// i2ctw_pkg
// Shared widths, constants and types for the I2C timing word calculator.
// ----------------------------------------------------------------------------
package i2ctw_pkg;

  localparam int unsigned SpeedW = 20;
  localparam int unsigned ClkW   = 28;
  localparam int unsigned DivW   = 28;  // dividend / quotient width
  localparam int unsigned DsrW   = 20;  // divisor width
  localparam int unsigned QW     = 7;   // small constant-division quotients
  localparam int unsigned CntW   = 9;   // clamped count, 1..256
  localparam int unsigned SumW   = 10;  // high + low + sync

  localparam logic [ClkW-1:0] BusClkReset = 28'd42000000;

  localparam logic [SpeedW-1:0] FastLimitHz = 20'd400000;
  localparam logic [SpeedW-1:0] StdLimitHz  = 20'd100000;

  localparam logic [6:0] FpHighNum   = 7'd88;
  localparam logic [6:0] FastHighNum = 7'd81;
  localparam logic [6:0] StdHighNum  = 7'd115;

  // reciprocal multipliers, floor(2^32 / divisor)
  localparam int unsigned RcpShift = 32;
  localparam int unsigned RcpW     = 11;
  localparam logic [RcpW-1:0] Rcp4M  = 11'd1073;
  localparam logic [RcpW-1:0] Rcp10M = 11'd429;
  localparam logic [RcpW-1:0] Rcp20M = 11'd214;
  localparam logic [24:0] Div4M  = 25'd4000000;
  localparam logic [24:0] Div10M = 25'd10000000;
  localparam logic [24:0] Div20M = 25'd20000000;

  localparam logic [3:0]      DelayMax = 4'd15;
  localparam logic [CntW-1:0] CountMax = 9'd256;

  typedef enum logic [1:0] {
    ModeStd  = 2'd0,
    ModeFast = 2'd1,
    ModeFp   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [ClkW-1:0]   clk;
    logic [3:0]        psc;
    logic [ClkW-1:0]   iclk;
    logic [3:0]        scl_dly;
    logic [3:0]        sda_dly;
    logic [CntW-1:0]   hi;
    logic [CntW-1:0]   lo;
  } side_t;

endpackage

/* src/i2ctw_div.sv */
// ----------------------------------------------------------------------------
// i2ctw_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module i2ctw_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [27:0]               dividend_i,
  input  logic [19:0]               divisor_i,
  input  i2ctw_pkg::side_t          side_i,
  output logic                      valid_o,
  output logic [27:0]               quotient_o,
  output i2ctw_pkg::side_t          side_o
);
  import i2ctw_pkg::*;

  logic [DivW-1:0] vld_q;
  logic [DivW-1:0] wrd_q [DivW];
  logic [DsrW-1:0] rem_q [DivW];
  logic [DsrW-1:0] dsr_q [DivW];
  side_t           side_q [DivW];

  for (genvar g = 0; g < DivW; g++) begin : gen_stage
    logic            vld_in;
    logic [DivW-1:0] wrd_in;
    logic [DsrW-1:0] rem_in;
    logic [DsrW-1:0] dsr_in;
    side_t           side_in;
    logic [DsrW:0]   trial;
    logic [DsrW:0]   diff;
    logic            ge;

    if (g == 0) begin : gen_first
      assign vld_in  = valid_i;
      assign wrd_in  = dividend_i;
      assign rem_in  = '0;
      assign dsr_in  = divisor_i;
      assign side_in = side_i;
    end else begin : gen_next
      assign vld_in  = vld_q[g-1];
      assign wrd_in  = wrd_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign dsr_in  = dsr_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign trial = {rem_in, wrd_in[DivW-1]};
    assign diff  = trial - {1'b0, dsr_in};
    assign ge    = trial >= {1'b0, dsr_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        wrd_q[g]  <= {wrd_in[DivW-2:0], ge};
        rem_q[g]  <= ge ? diff[DsrW-1:0] : trial[DsrW-1:0];
        dsr_q[g]  <= dsr_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o    = vld_q[DivW-1];
  assign quotient_o = wrd_q[DivW-1];
  assign side_o     = side_q[DivW-1];

endmodule

/* src/i2c_timing_word_calculator.sv */
// ----------------------------------------------------------------------------
// i2c_timing_word_calculator
// Derives I2C prescaler, SCL high/low counts and delays from a bus speed.
// ----------------------------------------------------------------------------
// One result per request, one request per cycle while the output is not
// stalled. The path is four 28-stage pipelined dividers (clock/speed,
// clock/(prescale+1), divided clock/speed, divided clock/(high+low+sync))
// plus three stages for constant divisions, mode rules and clamping, and
// the output register. A stalled output freezes the whole pipeline.
module i2c_timing_word_calculator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // speed_hz[19:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // prescale, scl_delay, sda_delay,
                                      // high_count_minus_one,
                                      // low_count_minus_one, timing_word,
                                      // achieved_speed_hz
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [27:0] cfg_data_i
);
  import i2ctw_pkg::*;

  logic en;
  logic [ClkW-1:0] bus_clk_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_clk_q <= BusClkReset;
    end else if (cfg_valid_i) begin
      bus_clk_q <= cfg_data_i;
    end
  end

  assign en            = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;

  // clock / speed
  logic [SpeedW-1:0] speed_in;
  side_t             side0, side1, side2, side3, side4;
  logic              vld1, vld2, vld3, vld4;
  logic [DivW-1:0]   quo1, quo2, quo3, quo4;

  assign speed_in = (s_axis_tdata[SpeedW-1:0] == '0) ? SpeedW'(1)
                                                      : s_axis_tdata[SpeedW-1:0];
  always_comb begin
    side0       = '0;
    side0.speed = speed_in;
    side0.clk   = bus_clk_q;
  end

  i2ctw_div u_div_psc (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid),
    .dividend_i(bus_clk_q), .divisor_i(speed_in), .side_i(side0),
    .valid_o(vld1), .quotient_o(quo1), .side_o(side1)
  );

  // clock / (prescale + 1)
  logic [3:0] psc;
  side_t      side1p;
  assign psc = (quo1[DivW-1:8] > DivW'(DelayMax)) ? DelayMax : quo1[11:8];
  always_comb begin
    side1p     = side1;
    side1p.psc = psc;
  end

  i2ctw_div u_div_iclk (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld1),
    .dividend_i(side1.clk), .divisor_i(DsrW'(psc) + DsrW'(1)), .side_i(side1p),
    .valid_o(vld2), .quotient_o(quo2), .side_o(side2)
  );

  // divided clock / speed
  side_t side2p;
  always_comb begin
    side2p      = side2;
    side2p.iclk = quo2;
  end

  i2ctw_div u_div_tcyc (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld2),
    .dividend_i(quo2), .divisor_i(side2.speed), .side_i(side2p),
    .valid_o(vld3), .quotient_o(quo3), .side_o(side3)
  );

  // C1: reciprocal products, mode, raw high count
  mode_e          mode;
  logic [6:0]     hnum;
  logic [38:0]    p4, p10, p20;
  logic [34:0]    hprod;

  always_comb begin
    if (side3.speed > FastLimitHz) begin
      mode = ModeFp;
    end else if (side3.speed > StdLimitHz) begin
      mode = ModeFast;
    end else begin
      mode = ModeStd;
    end
    case (mode)
      ModeFp:   hnum = FpHighNum;
      ModeFast: hnum = FastHighNum;
      ModeStd:  hnum = StdHighNum;
      default:  hnum = StdHighNum;
    endcase
  end

  assign p4    = 39'(side3.iclk) * 39'(Rcp4M);
  assign p10   = 39'(side3.iclk) * 39'(Rcp10M);
  assign p20   = 39'(side3.iclk) * 39'(Rcp20M);
  assign hprod = 35'(hnum) * 35'(quo3);

  logic              c1_vld_q;
  side_t             c1_side_q;
  mode_e             c1_mode_q;
  logic [DivW-1:0]   c1_tcyc_q;
  logic [26:0]       c1_hraw_q;
  logic [6:0]        c1_q4_q, c1_q10_q, c1_q20_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_vld_q <= 1'b0;
    end else if (en) begin
      c1_vld_q <= vld3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_side_q <= side3;
      c1_mode_q <= mode;
      c1_tcyc_q <= quo3;
      c1_hraw_q <= hprod[34:8];
      c1_q4_q   <= p4[38:RcpShift];
      c1_q10_q  <= p10[38:RcpShift];
      c1_q20_q  <= p20[38:RcpShift];
    end
  end

  // C2: correct the constant-division estimates
  logic [31:0] r4, r10, r20;
  logic [QW-1:0] sync_d, d10_d, d20_d;

  assign r4  = 32'(c1_side_q.iclk) - 32'(c1_q4_q)  * 32'(Div4M);
  assign r10 = 32'(c1_side_q.iclk) - 32'(c1_q10_q) * 32'(Div10M);
  assign r20 = 32'(c1_side_q.iclk) - 32'(c1_q20_q) * 32'(Div20M);
  assign sync_d = QW'(c1_q4_q)  + QW'(r4  >= 32'(Div4M));
  assign d10_d  = QW'(c1_q10_q) + QW'(r10 >= 32'(Div10M));
  assign d20_d  = QW'(c1_q20_q) + QW'(r20 >= 32'(Div20M));

  logic            c2_vld_q;
  side_t           c2_side_q;
  mode_e           c2_mode_q;
  logic [DivW-1:0] c2_tcyc_q;
  logic [26:0]     c2_hraw_q;
  logic [QW-1:0]   c2_sync_q, c2_d10_q, c2_d20_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_vld_q <= 1'b0;
    end else if (en) begin
      c2_vld_q <= c1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_side_q <= c1_side_q;
      c2_mode_q <= c1_mode_q;
      c2_tcyc_q <= c1_tcyc_q;
      c2_hraw_q <= c1_hraw_q;
      c2_sync_q <= sync_d;
      c2_d10_q  <= d10_d;
      c2_d20_q  <= d20_d;
    end
  end

  // C3: delays, low count, clamping
  logic [QW-1:0]      cl_raw, da_raw;
  logic [3:0]         cl_sat, da_sat;
  logic signed [28:0] lo_raw;
  logic [CntW-1:0]    hi_c, lo_c;

  always_comb begin
    case (c2_mode_q)
      ModeFp: begin
        cl_raw = c2_d20_q;
        da_raw = '0;
      end
      ModeFast: begin
        cl_raw = c2_d10_q;
        da_raw = c2_d20_q + QW'(1);
      end
      ModeStd: begin
        cl_raw = c2_sync_q;
        da_raw = c2_d20_q + QW'(1);
      end
      default: begin
        cl_raw = c2_sync_q;
        da_raw = c2_d20_q + QW'(1);
      end
    endcase
    cl_sat = (cl_raw > QW'(DelayMax)) ? DelayMax : cl_raw[3:0];
    da_sat = (da_raw > QW'(DelayMax)) ? DelayMax : da_raw[3:0];

    lo_raw = $signed({1'b0, c2_tcyc_q}) - $signed({2'b0, c2_hraw_q})
           - $signed({22'b0, c2_sync_q});

    if (c2_hraw_q == '0) begin
      hi_c = CntW'(1);
    end else if (c2_hraw_q > 27'(CountMax)) begin
      hi_c = CountMax;
    end else begin
      hi_c = c2_hraw_q[CntW-1:0];
    end

    if (lo_raw < 29'sd1) begin
      lo_c = CntW'(1);
    end else if (lo_raw > $signed({20'b0, CountMax})) begin
      lo_c = CountMax;
    end else begin
      lo_c = lo_raw[CntW-1:0];
    end
  end

  logic          c3_vld_q;
  side_t         c3_side_d;
  side_t         c3_side_q;
  logic [QW-1:0] c3_sync_q;

  always_comb begin
    c3_side_d         = c2_side_q;
    c3_side_d.scl_dly = cl_sat;
    c3_side_d.sda_dly = da_sat;
    c3_side_d.hi      = hi_c;
    c3_side_d.lo      = lo_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_vld_q <= 1'b0;
    end else if (en) begin
      c3_vld_q <= c2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_side_q <= c3_side_d;
      c3_sync_q <= c2_sync_q;
    end
  end

  // divided clock / (high + low + sync)
  logic [SumW-1:0] cnt_sum;
  assign cnt_sum = SumW'(c3_side_q.hi) + SumW'(c3_side_q.lo) + SumW'(c3_sync_q);

  i2ctw_div u_div_speed (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c3_vld_q),
    .dividend_i(c3_side_q.iclk), .divisor_i(DsrW'(cnt_sum)), .side_i(c3_side_q),
    .valid_o(vld4), .quotient_o(quo4), .side_o(side4)
  );

  // output register
  logic [7:0]  hi_m1, lo_m1;
  logic [31:0] word;
  logic        out_vld_q;
  logic [87:0] out_data_q;

  assign hi_m1 = 8'(side4.hi - CntW'(1));
  assign lo_m1 = 8'(side4.lo - CntW'(1));
  assign word  = {side4.psc, 4'b0, side4.scl_dly, side4.sda_dly, hi_m1, lo_m1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {quo4, word, lo_m1, hi_m1, side4.sda_dly, side4.scl_dly, side4.psc};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_word_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[59:56] == m_axis_tdata[3:0]) &&
                      (m_axis_tdata[51:48] == m_axis_tdata[7:4]) &&
                      (m_axis_tdata[47:44] == m_axis_tdata[11:8]) &&
                      (m_axis_tdata[43:36] == m_axis_tdata[19:12]) &&
                      (m_axis_tdata[35:28] == m_axis_tdata[27:20]) &&
                      (m_axis_tdata[55:52] == 4'b0))
    else $error("timing word does not match its fields");

  a_stall_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (m_axis_tready || !m_axis_tvalid))
    else $error("input ready does not follow pipeline enable");

  a_sda_fastplus : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c3_vld_q && (c3_side_q.speed > FastLimitHz)) |-> (c3_side_q.sda_dly == 4'd0))
    else $error("fast-plus item has nonzero data hold delay");

endmodule

/* tb/i2c_timing_word_calculator_tb.sv */
// ----------------------------------------------------------------------------
// i2c_timing_word_calculator_tb
// Self-checking testbench for the I2C timing word calculator.
// ----------------------------------------------------------------------------
// Drives requested speeds through the input stream and checks every timing
// result against a local model of the mode rules, clamps and divisions.
// Directed table first, then random speeds under several bus clock settings,
// with random gaps on both sides, a long output hold-off and a drain pause.
module i2c_timing_word_calculator_tb;
  import i2ctw_pkg::*;

  localparam int unsigned Latency = 116;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [27:0] achieved;
    logic [31:0] word;
    logic [7:0]  lo_m1;
    logic [7:0]  hi_m1;
    logic [3:0]  sda_dly;
    logic [3:0]  scl_dly;
    logic [3:0]  psc;
  } timing_t;

  typedef struct {
    logic [19:0] speed;
    bit          known;
    timing_t     res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [27:0] cfg_data_i = '0;

  logic [27:0] bus_clk_model;
  timing_t     timing_q[$];
  int          n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;

  always #5 clk_i = ~clk_i;

  i2c_timing_word_calculator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  function automatic longint clamp_cnt(longint v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic timing_t calc_timing(logic [27:0] bclk, logic [19:0] spd_in);
    longint unsigned spd, clk, psc, iclk, sync, tcyc, hi_raw, cdel, ddel, ach;
    longint hi, lo;
    timing_t r;
    spd = (spd_in == 0) ? 1 : spd_in;
    clk = bclk;
    psc = (clk / spd) >> 8;
    if (psc > 15) psc = 15;
    iclk = clk / (psc + 1);
    sync = iclk / 4000000;
    tcyc = iclk / spd;
    if (spd > FastLimitHz) begin
      hi_raw = (88 * tcyc) >> 8;
      cdel = iclk / 20000000;
      ddel = 0;
    end else if (spd > StdLimitHz) begin
      hi_raw = (81 * tcyc) >> 8;
      cdel = iclk / 10000000;
      ddel = 1 + iclk / 20000000;
    end else begin
      hi_raw = (115 * tcyc) >> 8;
      cdel = iclk / 4000000;
      ddel = 1 + iclk / 20000000;
    end
    lo = longint'(tcyc) - longint'(hi_raw) - longint'(sync);
    hi = clamp_cnt(longint'(hi_raw));
    lo = clamp_cnt(lo);
    if (cdel > 15) cdel = 15;
    if (ddel > 15) ddel = 15;
    ach = iclk / (longint'(hi) + longint'(lo) + sync);
    r.psc = psc[3:0];
    r.scl_dly = cdel[3:0];
    r.sda_dly = ddel[3:0];
    r.hi_m1 = 8'(hi - 1);
    r.lo_m1 = 8'(lo - 1);
    r.word = {psc[3:0], 4'd0, cdel[3:0], ddel[3:0], 8'(hi - 1), 8'(lo - 1)};
    r.achieved = ach[27:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("i2c_timing_word_calculator regression: fail");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    timing_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (timing_q.size() == 0) begin
        report_mismatch("unexpected item", got.word, 0);
      end else begin
        exp = timing_q.pop_front();
        if (got.psc !== exp.psc) report_mismatch("prescale", got.psc, exp.psc);
        if (got.scl_dly !== exp.scl_dly) report_mismatch("scl_delay", got.scl_dly, exp.scl_dly);
        if (got.sda_dly !== exp.sda_dly) report_mismatch("sda_delay", got.sda_dly, exp.sda_dly);
        if (got.hi_m1 !== exp.hi_m1) report_mismatch("high_count", got.hi_m1, exp.hi_m1);
        if (got.lo_m1 !== exp.lo_m1) report_mismatch("low_count", got.lo_m1, exp.lo_m1);
        if (got.word !== exp.word) report_mismatch("timing_word", got.word, exp.word);
        if (got.achieved !== exp.achieved)
          report_mismatch("achieved_speed", got.achieved, exp.achieved);
      end
    end
  end

  // output backpressure
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_speed(logic [19:0] spd, bit known = 0, timing_t exp_res = '0);
    timing_t pred;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, spd};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = calc_timing(bus_clk_model, spd);
    if (known && pred !== exp_res) report_mismatch("table row", pred.word, exp_res.word);
    timing_q.push_back(pred);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (timing_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_bus_clk(logic [27:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bus_clk_model = v;
  endtask

  function automatic logic [19:0] rand_speed();
    case ($urandom_range(5))
      0: return 20'($urandom_range(1000000, 400001));
      1: return 20'($urandom_range(400001, 100001));
      2: return 20'($urandom_range(100000, 1000));
      3: return 20'($urandom_range(1000, 0));
      4: return 20'($urandom);
      default: return 20'($urandom_range(400002, 399998));
    endcase
  endfunction

  row_t dir_rows[$];
  logic [27:0] clk_set[] = '{28'd4000000, 28'd200000000, 28'hFFFFFFF, 28'd0,
                             28'd16000000, 28'd42000000};
  logic [19:0] dspd[] = '{20'd0, 20'd1, 20'd100000, 20'd100001, 20'd400000,
                          20'd400001, 20'd1000000, 20'hFFFFF, 20'd10000,
                          20'd1000, 20'd50, 20'h55555, 20'hAAAAA};

  initial begin
    row_t r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    bus_clk_model = BusClkReset;

    // 100 kHz at reset clock: psc 1, iclk 21 MHz, t 210, hi 94, sync 5, lo 111
    r.speed = 20'd100000; r.known = 1;
    r.res = '{achieved: 28'd100000, word: {4'd1, 4'd0, 4'd5, 4'd2, 8'd93, 8'd110},
              lo_m1: 8'd110, hi_m1: 8'd93, sda_dly: 4'd2, scl_dly: 4'd5, psc: 4'd1};
    dir_rows.push_back(r);
    foreach (dspd[i]) begin
      r.speed = dspd[i]; r.known = 0; r.res = '0;
      dir_rows.push_back(r);
    end
    foreach (dir_rows[i]) send_speed(dir_rows[i].speed, dir_rows[i].known, dir_rows[i].res);
    foreach (clk_set[c]) begin
      write_bus_clk(clk_set[c]);
      foreach (dspd[i]) send_speed(dspd[i]);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 47 : 0;
      recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 19 : 0;
      for (int b = 0; b < 4; b++) begin
        write_bus_clk((b == 0) ? 28'($urandom_range(200000000, 4000000)) :
                      (b == 1) ? 28'($urandom) : clk_set[$urandom_range(5)]);
        if (ph == 2 && b == 0) hold_cycles = 400;
        repeat (160) send_speed(rand_speed());
        if (b == 1) drain();
      end
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    if (n_errors == 0) begin
      $display("i2c_timing_word_calculator regression: pass");
    end else begin
      $display("i2c_timing_word_calculator regression: fail");
    end
    $finish;
  end

endmodule
